[design/tcvs_pkg.sv]
// ----------------------------------------------------------------------------
// tcvs_pkg
// Shared types and constants for the tile color variance statistics block:
// grid geometry, tile accumulator layout, register codes and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package tcvs_pkg;

	// grid geometry
	localparam int TILES_PER_SIDE = 8;
	localparam int MAX_DIMENSION  = 4096;
	localparam int TILE_BITS      = $clog2(TILES_PER_SIDE);
	localparam int TILE_COUNT     = TILES_PER_SIDE * TILES_PER_SIDE;
	localparam int IDX_BITS       = $clog2(TILE_COUNT);
	localparam int TILE_SPAN      = (MAX_DIMENSION + TILES_PER_SIDE - 1) / TILES_PER_SIDE;
	localparam int TILE_CAP       = TILE_SPAN * TILE_SPAN;

	// field widths
	localparam int COORD_W = 12;
	localparam int LEN_W   = 13;
	localparam int CHAN_W  = 8;
	localparam int VAR_W   = 14;
	localparam int CNT_W   = 19;
	localparam int CSUM_W  = 26;
	localparam int LSUM_W  = 28;
	localparam int QSUM_W  = 38;

	// report sequencing
	localparam int MUL_STEPS = 4;
	localparam int DIV_STEPS = VAR_W;
	localparam int STEP_W    = 4;

	// multiply steps of the report
	localparam logic [STEP_W-1:0] MUL_NQ_LO = 4'd0;
	localparam logic [STEP_W-1:0] MUL_NQ_HI = 4'd1;
	localparam logic [STEP_W-1:0] MUL_SS    = 4'd2;
	localparam logic [STEP_W-1:0] MUL_NN    = 4'd3;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ROI_X_START = 2'd0,
		REG_ROI_Y_START = 2'd1,
		REG_ROI_WIDTH   = 2'd2,
		REG_ROI_HEIGHT  = 2'd3
	} reg_idx_t;

	// per-tile accumulator word
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [CSUM_W-1:0] red;
		logic [CSUM_W-1:0] green;
		logic [CSUM_W-1:0] blue;
		logic [LSUM_W-1:0] luma;
		logic [QSUM_W-1:0] sq;
	} tile_acc_t;

	// controller to datapath
	typedef struct packed {
		logic              pix_latch;
		logic              pix_rd;
		logic              pix_wr;
		logic              rpt_start;
		logic              rpt_rd;
		logic              rpt_load;
		logic              mul_en;
		logic              num_en;
		logic              pre_en;
		logic              div_en;
		logic              out_load;
		logic              rpt_next;
		logic              clear_all;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rpt_last;
	} dp_sts_t;

endpackage

[design/tcvs_ctrl.sv]
// ----------------------------------------------------------------------------
// tcvs_ctrl
// Sequencer: one pixel as read-modify-write of its tile, or a report that
// walks all tiles through load, multiply, divide and output.
// ----------------------------------------------------------------------------
module tcvs_ctrl
	import tcvs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_cmd,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output logic    in_stall,
	output logic    out_valid,
	output dp_cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_PX_RD = 11'b000_0000_0010,
		ST_PX_WR = 11'b000_0000_0100,
		ST_RP_RD = 11'b000_0000_1000,
		ST_RP_LD = 11'b000_0001_0000,
		ST_RP_MU = 11'b000_0010_0000,
		ST_RP_NU = 11'b000_0100_0000,
		ST_RP_PR = 11'b000_1000_0000,
		ST_RP_DV = 11'b001_0000_0000,
		ST_RP_FN = 11'b010_0000_0000,
		ST_RP_OU = 11'b100_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_RP_OU);
	assign accept    = in_valid && !in_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.step = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd) begin
						cmd.rpt_start = 1'b1;
						state_d       = ST_RP_RD;
					end else begin
						cmd.pix_latch = 1'b1;
						state_d       = ST_PX_RD;
					end
				end
			end
			ST_PX_RD: begin
				cmd.pix_rd = 1'b1;
				state_d    = ST_PX_WR;
			end
			ST_PX_WR: begin
				cmd.pix_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RP_RD: begin
				cmd.rpt_rd = 1'b1;
				state_d    = ST_RP_LD;
			end
			ST_RP_LD: begin
				cmd.rpt_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_RP_MU;
			end
			ST_RP_MU: begin
				cmd.mul_en = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MUL_STEPS - 1))
					state_d = ST_RP_NU;
			end
			ST_RP_NU: begin
				cmd.num_en = 1'b1;
				state_d    = ST_RP_PR;
			end
			ST_RP_PR: begin
				cmd.pre_en = 1'b1;
				cnt_d      = STEP_W'(DIV_STEPS - 1);
				state_d    = ST_RP_DV;
			end
			ST_RP_DV: begin
				cmd.div_en = 1'b1;
				if (cnt_q == '0)
					state_d = ST_RP_FN;
				else
					cnt_d = cnt_q - 1'b1;
			end
			ST_RP_FN: begin
				cmd.out_load = 1'b1;
				state_d      = ST_RP_OU;
			end
			ST_RP_OU: begin
				if (!out_stall) begin
					if (sts.rpt_last) begin
						cmd.clear_all = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.rpt_next = 1'b1;
						state_d      = ST_RP_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[design/tcvs_dp.sv]
// ----------------------------------------------------------------------------
// tcvs_dp
// Datapath: region registers, tile binning, accumulator memory with valid
// bits, shared multiplier and restoring dividers for averages and variance.
// ----------------------------------------------------------------------------
module tcvs_dp
	import tcvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic [COORD_W-1:0]   pixel_x,
	input  logic [COORD_W-1:0]   pixel_y,
	input  logic [CHAN_W-1:0]    red,
	input  logic [CHAN_W-1:0]    green,
	input  logic [CHAN_W-1:0]    blue,
	output logic [TILE_BITS-1:0] tile_row,
	output logic [TILE_BITS-1:0] tile_col,
	output logic [CHAN_W-1:0]    avg_red,
	output logic [CHAN_W-1:0]    avg_green,
	output logic [CHAN_W-1:0]    avg_blue,
	output logic [VAR_W-1:0]     luma_variance,
	output logic                 last_tile
);

	localparam int LS_W  = 10;
	localparam int PRD_W = 56;
	localparam int NN_W  = 2 * CNT_W;
	localparam int DEN_W = NN_W + 4;
	localparam int DV_W  = DEN_W + 1;
	localparam int REM_W = PRD_W + 2;
	localparam int CR_W  = CSUM_W + 1;
	localparam int CQ_W  = $clog2(CHAN_W);
	localparam int Q_HALF = QSUM_W / 2;

	// bin offset d into a tile: floor((T*d + T-1) / len), quotient below T
	function automatic logic [TILE_BITS-1:0] bin_div(
		input logic [COORD_W-1:0] d,
		input logic [LEN_W-1:0]   len
	);
		logic [COORD_W+TILE_BITS:0] rem;
		logic [COORD_W+TILE_BITS:0] sh;
		logic [TILE_BITS-1:0]       q;
		rem = {1'b0, d, {TILE_BITS{1'b0}}} + (COORD_W+TILE_BITS+1)'(TILES_PER_SIDE - 1);
		q   = '0;
		for (int i = TILE_BITS - 1; i >= 0; i--) begin
			sh = (COORD_W+TILE_BITS+1)'(len) << i;
			if (rem >= sh) begin
				rem  = rem - sh;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// region registers
	logic [COORD_W-1:0] x0_q, y0_q;
	logic [LEN_W-1:0]   w_q, h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= '0;
			y0_q <= '0;
			w_q  <= LEN_W'(MAX_DIMENSION);
			h_q  <= LEN_W'(MAX_DIMENSION);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROI_X_START: x0_q <= cfg_data[COORD_W-1:0];
				REG_ROI_Y_START: y0_q <= cfg_data[COORD_W-1:0];
				REG_ROI_WIDTH:   w_q  <= cfg_data;
				REG_ROI_HEIGHT:  h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// binning of the incoming word
	logic [COORD_W-1:0] dx, dy;
	logic               in_x, in_y;

	assign dx   = pixel_x - x0_q;
	assign dy   = pixel_y - y0_q;
	assign in_x = (w_q != '0) && (pixel_x >= x0_q) && ({1'b0, dx} < w_q);
	assign in_y = (h_q != '0) && (pixel_y >= y0_q) && ({1'b0, dy} < h_q);

	logic [IDX_BITS-1:0] tile_q;
	logic                in_roi_q;
	logic [CHAN_W-1:0]   r_q, g_q, b_q;

	// latch pixel and its tile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_roi_q <= 1'b0;
		end else if (cmd.pix_latch) begin
			in_roi_q <= in_x && in_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_latch) begin
			tile_q <= {bin_div(dy, h_q), bin_div(dx, w_q)};
			r_q    <= red;
			g_q    <= green;
			b_q    <= blue;
		end
	end

	// report tile index
	logic [IDX_BITS-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.rpt_start) begin
			idx_q <= '0;
		end else if (cmd.rpt_next) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign sts.rpt_last = (idx_q == IDX_BITS'(TILE_COUNT - 1));

	// accumulator memory, registered read
	tile_acc_t           mem [TILE_COUNT];
	tile_acc_t           rdata_q;
	logic [TILE_COUNT-1:0] valid_q;
	logic                rvalid_q;
	logic [IDX_BITS-1:0] raddr;
	tile_acc_t           cur, upd;
	logic [LS_W-1:0]     s_sum;
	logic                do_wr;

	assign raddr = cmd.rpt_rd ? idx_q : tile_q;

	always_ff @(posedge clk) begin
		if (cmd.pix_rd || cmd.rpt_rd) begin
			rdata_q  <= mem[raddr];
			rvalid_q <= valid_q[raddr];
		end
		if (do_wr)
			mem[tile_q] <= upd;
	end

	// entries never written since the last clear read as zero
	assign cur   = rvalid_q ? rdata_q : '0;
	assign s_sum = LS_W'(r_q) + LS_W'(g_q) + LS_W'(b_q);
	assign do_wr = cmd.pix_wr && in_roi_q && (cur.cnt < CNT_W'(TILE_CAP));

	always_comb begin
		upd.cnt   = cur.cnt + 1'b1;
		upd.red   = cur.red + CSUM_W'(r_q);
		upd.green = cur.green + CSUM_W'(g_q);
		upd.blue  = cur.blue + CSUM_W'(b_q);
		upd.luma  = cur.luma + LSUM_W'(s_sum);
		upd.sq    = cur.sq + QSUM_W'(s_sum * s_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (do_wr) begin
			valid_q[tile_q] <= 1'b1;
		end
	end

	// tile under report
	tile_acc_t t_q;

	always_ff @(posedge clk) begin
		if (cmd.rpt_load)
			t_q <= cur;
	end

	// shared multiplier: n*Q in two halves, S*S, n*n
	logic [LSUM_W-1:0] mul_a, mul_b;
	logic [PRD_W-1:0]  prod;
	logic [PRD_W-1:0]  nq_q, ss_q;
	logic [NN_W-1:0]   nn_q;

	always_comb begin
		unique case (cmd.step)
			MUL_NQ_LO: begin
				mul_a = LSUM_W'(t_q.cnt);
				mul_b = LSUM_W'(t_q.sq[Q_HALF-1:0]);
			end
			MUL_NQ_HI: begin
				mul_a = LSUM_W'(t_q.cnt);
				mul_b = LSUM_W'(t_q.sq[QSUM_W-1:Q_HALF]);
			end
			MUL_SS: begin
				mul_a = t_q.luma;
				mul_b = t_q.luma;
			end
			default: begin
				mul_a = LSUM_W'(t_q.cnt);
				mul_b = LSUM_W'(t_q.cnt);
			end
		endcase
	end

	assign prod = PRD_W'(mul_a) * PRD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.step)
				MUL_NQ_LO: nq_q <= prod;
				MUL_NQ_HI: nq_q <= nq_q + {prod[PRD_W-Q_HALF-1:0], {Q_HALF{1'b0}}};
				MUL_SS:    ss_q <= prod;
				default:   nn_q <= prod[NN_W-1:0];
			endcase
		end
	end

	// numerator and denominator
	logic [PRD_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	always_ff @(posedge clk) begin
		if (cmd.num_en) begin
			num_q <= (nq_q > ss_q) ? (nq_q - ss_q) : '0;
			den_q <= {DEN_W'(nn_q) << 3} + DEN_W'(nn_q);
		end
	end

	// restoring dividers: variance all steps, channel lanes the low 8 steps
	logic [REM_W-1:0]  vrem_q;
	logic [DV_W-1:0]   dv_q;
	logic [VAR_W-1:0]  vq_q;
	logic [CR_W-1:0]   crem_q [3];
	logic [CHAN_W-1:0] cq_q   [3];
	logic [REM_W-1:0]  vsh;
	logic [CR_W-1:0]   csh;
	logic              cact;

	assign vsh  = REM_W'(dv_q) << cmd.step;
	assign csh  = CR_W'(t_q.cnt) << cmd.step[CQ_W-1:0];
	assign cact = (cmd.step < STEP_W'(CHAN_W));

	always_ff @(posedge clk) begin
		if (cmd.pre_en) begin
			vrem_q    <= REM_W'({num_q, 1'b0}) + REM_W'(den_q);
			dv_q      <= {den_q, 1'b0};
			vq_q      <= '0;
			crem_q[0] <= CR_W'(t_q.red);
			crem_q[1] <= CR_W'(t_q.green);
			crem_q[2] <= CR_W'(t_q.blue);
			for (int i = 0; i < 3; i++)
				cq_q[i] <= '0;
		end else if (cmd.div_en) begin
			if (vrem_q >= vsh) begin
				vrem_q                       <= vrem_q - vsh;
				vq_q[cmd.step]               <= 1'b1;
			end
			if (cact) begin
				for (int i = 0; i < 3; i++) begin
					if (crem_q[i] >= csh) begin
						crem_q[i]                     <= crem_q[i] - csh;
						cq_q[i][cmd.step[CQ_W-1:0]] <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	logic empty;

	assign empty = (t_q.cnt == '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tile_row      <= idx_q[IDX_BITS-1:TILE_BITS];
			tile_col      <= idx_q[TILE_BITS-1:0];
			avg_red       <= empty ? '0 : cq_q[0];
			avg_green     <= empty ? '0 : cq_q[1];
			avg_blue      <= empty ? '0 : cq_q[2];
			luma_variance <= empty ? '0 : vq_q;
			last_tile     <= sts.rpt_last;
		end
	end

endmodule

[design/tile_color_variance_stats.sv]
// Pixel word: binned at acceptance, then its tile is read and written back; no new
// word is taken until the read-modify-write of the tile memory is done.
// Report word: each of the 64 tiles in turn goes through read, load, 4 multiply,
// 2 setup, 14 divide, output load and output steps on the shared units, plus output
// stall; no new word is taken until the report ends.
// Reset: control state and tile valid bits clear at once, region registers take
// their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// tile_color_variance_stats
// Per-tile color averages and luminance variance over a region of interest.
// ----------------------------------------------------------------------------
module tile_color_variance_stats
	import tcvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [COORD_W-1:0]   pixel_x,
	input  logic [COORD_W-1:0]   pixel_y,
	input  logic [CHAN_W-1:0]    red,
	input  logic [CHAN_W-1:0]    green,
	input  logic [CHAN_W-1:0]    blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TILE_BITS-1:0] tile_row,
	output logic [TILE_BITS-1:0] tile_col,
	output logic [CHAN_W-1:0]    avg_red,
	output logic [CHAN_W-1:0]    avg_green,
	output logic [CHAN_W-1:0]    avg_blue,
	output logic [VAR_W-1:0]     luma_variance,
	output logic                 last_tile
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tcvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (command),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	tcvs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.tile_row      (tile_row),
		.tile_col      (tile_col),
		.avg_red       (avg_red),
		.avg_green     (avg_green),
		.avg_blue      (avg_blue),
		.luma_variance (luma_variance),
		.last_tile     (last_tile)
	);

`ifndef SYNTHESIS
	// no new word is taken while a result is pending
	a_busy_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during report");

	// the report ends after its final tile
	a_end_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_tile) |=> !out_valid)
		else $error("report continues past final tile");

	// the final tile is the bottom-right corner
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_tile) |->
		(tile_row == TILE_BITS'(TILES_PER_SIDE - 1)) &&
		(tile_col == TILE_BITS'(TILES_PER_SIDE - 1)))
		else $error("final tile flag misplaced");
`endif

endmodule

[verif/tcvs_checker.sv]
// ----------------------------------------------------------------------------
// tcvs_checker
// Watches the register port and both word channels of the tile statistics
// block. It keeps its own tile accumulators and region registers, builds the
// 64 expected tile words of every report and compares each accepted output
// word field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module tcvs_checker
	import tcvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 command,
	input  logic [COORD_W-1:0]   pixel_x,
	input  logic [COORD_W-1:0]   pixel_y,
	input  logic [CHAN_W-1:0]    red,
	input  logic [CHAN_W-1:0]    green,
	input  logic [CHAN_W-1:0]    blue,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [TILE_BITS-1:0] tile_row,
	input  logic [TILE_BITS-1:0] tile_col,
	input  logic [CHAN_W-1:0]    avg_red,
	input  logic [CHAN_W-1:0]    avg_green,
	input  logic [CHAN_W-1:0]    avg_blue,
	input  logic [VAR_W-1:0]     luma_variance,
	input  logic                 last_tile,
	output int                   fail_count,
	output int                   tiles_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [TILE_BITS-1:0] row;
		logic [TILE_BITS-1:0] col;
		logic [CHAN_W-1:0]    r;
		logic [CHAN_W-1:0]    g;
		logic [CHAN_W-1:0]    b;
		logic [VAR_W-1:0]     var_q;
		logic                 last;
	} tile_word_t;

	logic [COORD_W-1:0] x0, y0;
	logic [LEN_W-1:0]   roi_w, roi_h;
	longint unsigned    n_pix[TILE_COUNT];
	longint unsigned    sum_r[TILE_COUNT], sum_g[TILE_COUNT], sum_b[TILE_COUNT];
	longint unsigned    sum_s[TILE_COUNT], sum_sq[TILE_COUNT];
	tile_word_t         tile_words_due[$];

	// find grid bin of one coordinate; returns 0 when outside the region
	function automatic bit grid_bin(input int unsigned p, input int unsigned start,
			input int unsigned len, output int unsigned bin);
		int unsigned d;
		bin = 0;
		if (len == 0 || p < start) return 0;
		d = p - start;
		if (d >= len) return 0;
		bin = (TILES_PER_SIDE * d + TILES_PER_SIDE - 1) / len;
		if (bin >= TILES_PER_SIDE) bin = TILES_PER_SIDE - 1;
		return 1;
	endfunction

	function automatic void clear_tiles();
		for (int k = 0; k < TILE_COUNT; k++) begin
			n_pix[k] = 0; sum_r[k] = 0; sum_g[k] = 0; sum_b[k] = 0;
			sum_s[k] = 0; sum_sq[k] = 0;
		end
	endfunction

	// bin one pixel and add it to its tile
	function automatic void add_pixel();
		int unsigned col, row, t;
		longint unsigned s;
		if (!grid_bin(pixel_x, x0, roi_w, col)) return;
		if (!grid_bin(pixel_y, y0, roi_h, row)) return;
		t = row * TILES_PER_SIDE + col;
		if (n_pix[t] >= TILE_CAP) return;
		s = red + green + blue;
		n_pix[t] += 1;
		sum_r[t] += red; sum_g[t] += green; sum_b[t] += blue;
		sum_s[t] += s;
		sum_sq[t] += s * s;
	endfunction

	// build all tile words of a report, then clear
	function automatic void queue_report();
		tile_word_t w;
		longint unsigned n, nq, ss, num, den;
		for (int k = 0; k < TILE_COUNT; k++) begin
			n = n_pix[k];
			w.row = TILE_BITS'(k / TILES_PER_SIDE);
			w.col = TILE_BITS'(k % TILES_PER_SIDE);
			w.r = '0; w.g = '0; w.b = '0; w.var_q = '0;
			if (n != 0) begin
				nq = n * sum_sq[k];
				ss = sum_s[k] * sum_s[k];
				num = (nq > ss) ? nq - ss : 0;
				den = 9 * n * n;
				w.r = CHAN_W'(sum_r[k] / n);
				w.g = CHAN_W'(sum_g[k] / n);
				w.b = CHAN_W'(sum_b[k] / n);
				w.var_q = VAR_W'((2 * num + den) / (2 * den));
			end
			w.last = (k == TILE_COUNT - 1);
			tile_words_due.push_back(w);
		end
		clear_tiles();
	endfunction

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tile_word_t w;
		if (!arst_n) begin
			x0 = '0; y0 = '0;
			roi_w = LEN_W'(MAX_DIMENSION); roi_h = LEN_W'(MAX_DIMENSION);
			clear_tiles();
			tile_words_due.delete();
			fail_count = 0;
			tiles_pending = 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ROI_X_START: x0 = cfg_data[COORD_W-1:0];
					REG_ROI_Y_START: y0 = cfg_data[COORD_W-1:0];
					REG_ROI_WIDTH:   roi_w = cfg_data;
					REG_ROI_HEIGHT:  roi_h = cfg_data;
					default: ;
				endcase
			end
			// predict accepted input words
			if (in_valid && !in_stall) begin
				if (command) queue_report();
				else add_pixel();
			end
			// compare accepted output words
			if (out_valid && !out_stall) begin
				if (tile_words_due.size() == 0) begin
					$error("tile word with nothing expected (row %0d col %0d)",
						tile_row, tile_col);
					fail_count++;
				end else begin
					w = tile_words_due.pop_front();
					check_field("tile_row", w.row, tile_row);
					check_field("tile_col", w.col, tile_col);
					check_field("avg_red", w.r, avg_red);
					check_field("avg_green", w.g, avg_green);
					check_field("avg_blue", w.b, avg_blue);
					check_field("luma_variance", w.var_q, luma_variance);
					check_field("last_tile", w.last, last_tile);
				end
			end
			tiles_pending = tile_words_due.size();
		end
	end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the tile statistics block: directed pixels at the region
// edges and coordinate extremes, empty and one-pixel regions, then random
// regions filled mostly with in-region pixels and closed by reports, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb
	import tcvs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_PIXEL  = 1'b0;
	localparam logic CMD_REPORT = 1'b1;
	localparam int   HOLD_CYCLES = 2500;
	localparam int   IDLE_LIMIT  = 20000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 command = CMD_PIXEL;
	logic [COORD_W-1:0]   pixel_x = '0;
	logic [COORD_W-1:0]   pixel_y = '0;
	logic [CHAN_W-1:0]    red = '0, green = '0, blue = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [TILE_BITS-1:0] tile_row, tile_col;
	logic [CHAN_W-1:0]    avg_red, avg_green, avg_blue;
	logic [VAR_W-1:0]     luma_variance;
	logic                 last_tile;
	int                   fail_count, tiles_pending;

	bit hold_req = 0;
	bit steady = 0;
	int pixels_sent = 0, reports_sent = 0, idle_cycles = 0;
	int unsigned cur_x0 = 0, cur_y0 = 0, cur_w = MAX_DIMENSION, cur_h = MAX_DIMENSION;

	always #2 clk = ~clk;

	tile_color_variance_stats DUT (.*);
	tcvs_checker u_checker (.*);

	// advance a watchdog over cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// drive output stall: random, calm stretch, or one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			out_stall <= !steady && ($urandom_range(0, 99) < 38);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [LEN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// drain outstanding tile words, then let the pixel pipeline settle
	task automatic set_region(input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h);
		if (in_valid) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		while (tiles_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		write_reg(REG_ROI_X_START, LEN_W'(x));
		write_reg(REG_ROI_Y_START, LEN_W'(y));
		write_reg(REG_ROI_WIDTH, LEN_W'(w));
		write_reg(REG_ROI_HEIGHT, LEN_W'(h));
		cur_x0 = x % 4096; cur_y0 = y % 4096; cur_w = w; cur_h = h;
	endtask

	// offer one word and hold it until accepted; entered and left at a falling edge
	task automatic send_word(input logic cmd, input int unsigned x, input int unsigned y,
			input int unsigned r, input int unsigned g, input int unsigned b);
		if (!steady && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pixel_x <= COORD_W'(x); pixel_y <= COORD_W'(y);
		red <= CHAN_W'(r); green <= CHAN_W'(g); blue <= CHAN_W'(b);
		forever begin
			@(posedge clk);
			if (!in_stall) break;
			@(negedge clk);
		end
		@(negedge clk);
		if (cmd == CMD_REPORT) reports_sent++;
		else pixels_sent++;
	endtask

	task automatic send_pixel(input int unsigned x, input int unsigned y,
			input int unsigned r, input int unsigned g, input int unsigned b);
		send_word(CMD_PIXEL, x, y, r, g, b);
	endtask

	task automatic send_report();
		send_word(CMD_REPORT, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	// pixel mostly inside the current region, sometimes anywhere
	task automatic send_random_pixel();
		int unsigned x, y;
		if (cur_w != 0 && cur_h != 0 && $urandom_range(0, 99) < 85) begin
			x = cur_x0 + $urandom_range(0, cur_w - 1);
			y = cur_y0 + $urandom_range(0, cur_h - 1);
			if (x > 4095) x = 4095;
			if (y > 4095) y = 4095;
		end else begin
			x = $urandom_range(0, 4095);
			y = $urandom_range(0, 4095);
		end
		send_pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
	endtask

	initial begin
		int unsigned w, h;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// full default region: corners, extremes, report, empty report
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(0, 0, 0, 0, 0);
		send_pixel(4095, 4095, 0, 0, 0);
		send_pixel(4095, 0, 255, 0, 170);
		send_pixel(0, 4095, 85, 255, 0);
		send_pixel(2048, 1024, 170, 85, 255);
		send_pixel(511, 512, 1, 2, 3);
		send_report();
		send_report();

		// one-pixel region at the far corner; x start written past 12 bits
		set_region(13'h1FFF, 4095, 1, 1);
		send_pixel(4095, 4095, 200, 100, 50);
		send_pixel(4094, 4095, 9, 9, 9);
		send_pixel(4095, 4094, 9, 9, 9);
		send_report();

		// zero width makes the region empty
		set_region(100, 200, 0, 50);
		send_pixel(100, 200, 7, 7, 7);
		send_pixel(150, 220, 7, 7, 7);
		send_report();

		// offset start, widest width, pixels at and just outside the region edges
		set_region(10, 20, 4096, 16);
		send_pixel(9, 20, 1, 1, 1);
		send_pixel(10, 35, 255, 255, 255);
		send_pixel(10, 36, 1, 1, 1);
		send_report();

		// random regions, mostly small, with one long output hold-off
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 3))
				0: w = $urandom_range(1, 16);
				1: w = MAX_DIMENSION;
				default: w = $urandom_range(8, 300);
			endcase
			h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(8, 300);
			set_region($urandom_range(0, 4095), $urandom_range(0, 4095), w, h);
			steady = (ph == 3);
			for (int i = 0; i < 55; i++) begin
				if (ph == 1 && i == 30) begin
					hold_req = 1;
					send_report();
				end else if ($urandom_range(0, 99) < 3) send_report();
				else send_random_pixel();
			end
			send_report();
			steady = 0;
		end

		in_valid <= 1'b0;
		while (tiles_pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("Covered %0d pixel words and %0d reports over varied regions,",
			pixels_sent, reports_sent);
		$display("including empty and one-pixel regions and a long output hold-off.");
		if (fail_count == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end

endmodule

[files.f]
design/tcvs_pkg.sv
design/tcvs_ctrl.sv
design/tcvs_dp.sv
design/tile_color_variance_stats.sv
verif/tcvs_checker.sv
verif/tb.sv
